[rtl/core/pis_pkg.sv]
// Shared types and constants of the point-in-sector test.
// Used by every module of the block; depends on nothing.
package pis_pkg;

    // Angles in 1/256 degree.
    localparam logic [16:0] FULL_TURN    = 17'd92160;
    localparam logic [16:0] THREE_QUART  = 17'd69120;
    localparam logic [16:0] HALF_TURN    = 17'd46080;
    localparam logic [16:0] QUARTER_TURN = 17'd23040;
    localparam logic [14:0] QUARTER_T15  = 15'd23040;
    localparam logic [14:0] EIGHTH_T15   = 15'd11520;

    // PI_Q30 = 46080 * PI_A + PI_B, so the radian scaling splits into an exact
    // product and a small remainder that is divided by 46080 through a reciprocal.
    localparam logic [16:0] PI_A      = 17'd73204;
    localparam logic [14:0] PI_B      = 15'd19106;
    localparam logic [27:0] ROUND_OFS = 28'd23040;
    localparam logic [26:0] X_RECIP   = 27'd95443718;
    localparam int          X_SHIFT   = 42;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

    localparam int HORNER_LAT = 3;
    localparam int SIN_STEPS  = 4;
    localparam int COS_STEPS  = 5;

    // Series divisors and floor(2^32 / k).
    localparam logic [6:0]  SIN_K [SIN_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [31:0] SIN_M [SIN_STEPS] =
        '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
    localparam logic [6:0]  COS_K [COS_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] COS_M [COS_STEPS] =
        '{32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

    // Stage bookkeeping: trig results land in stage TRIG_LAST, the decision
    // register is the last of PIPE_DEPTH stages.
    localparam int TRIG_LAST  = 21;
    localparam int PIPE_DEPTH = 27;
    localparam int PROD_W     = 120;

    typedef logic signed [25:0] trig_t;

    typedef enum logic [0:0] {
        REG_OPENING = 1'b0,
        REG_REACH   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dz;
        logic [65:0]        d2;
        logic               apex;
        logic               far;
    } geom_t;

endpackage

[rtl/core/pis_horner.sv]
// One Horner step of the sine/cosine series: h = 1 - round(x2 * t) / k.
// Three register stages; depends on pis_pkg.
module pis_horner
    import pis_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] x2,
    input  logic [30:0] t,
    input  logic [6:0]  k,
    input  logic [31:0] m,
    output logic [30:0] h
);

    logic [61:0] prod_reg;
    logic [30:0] p_reg;
    logic [30:0] p_next;
    logic [62:0] pm_reg;
    logic [30:0] q;
    logic [37:0] rem;
    logic [30:0] h_reg;
    logic [30:0] h_next;

    always_comb
    begin
        p_next = 31'((prod_reg + 62'(HALF_Q30)) >> 30);
    end

    // The reciprocal quotient is low by at most one.
    always_comb
    begin
        q   = 31'(pm_reg >> 32);
        rem = 38'(p_reg) - 38'(38'(q) * 38'(k));
        if (rem >= 38'(k))
        begin
            q = q + 31'd1;
        end
        h_next = ONE_Q30 - q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 62'(x2) * 62'(t);
            p_reg    <= p_next;
            pm_reg   <= 63'(p_next) * 63'(m);
            h_reg    <= h_next;
        end
    end

    assign h = h_reg;

endmodule

[rtl/core/pis_trig.sv]
// Pipelined sine and cosine in signed Q24 of an angle in 1/256 degree.
// Results advance only while en is high; depends on pis_pkg, pis_horner.
module pis_trig
    import pis_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [18:0] angle,
    output trig_t              sin_o,
    output trig_t              cos_o
);

    localparam int FOLD_DLY = 20;
    localparam int X_DLY    = HORNER_LAT * SIN_STEPS;
    localparam int X2_DLY   = HORNER_LAT * (COS_STEPS - 1);
    localparam logic signed [20:0] TURN_OFS [6] = '{-21'sd184320, -21'sd92160, 21'sd0,
                                                   21'sd92160, 21'sd184320, 21'sd276480};

    logic signed [20:0] cand;
    logic [16:0] r_reg, r_next;
    logic [1:0]  quad_next;
    logic [14:0] t_fold;
    logic        swap_next;
    logic [13:0] u_reg, u_next;
    logic [1:0]  quad_d [FOLD_DLY];
    logic        swap_d [FOLD_DLY];
    logic [29:0] au_reg;
    logic [27:0] nn_reg;
    logic [54:0] xprod;
    logic [29:0] x_reg, x4_reg, x5_reg;
    logic [29:0] x_d [X_DLY];
    logic [59:0] xx_reg;
    logic [30:0] x2_reg;
    logic [30:0] x2_d [X2_DLY];
    logic [30:0] sin_h [SIN_STEPS + 1];
    logic [30:0] cos_h [COS_STEPS + 1];
    logic [60:0] sp_reg;
    logic [30:0] sq_reg, sq2_reg;
    logic [24:0] s0, c0;
    trig_t       s_fin, c_fin;
    trig_t       sin_reg, sin_next, cos_reg, cos_next;

    // Reduce modulo a full turn: exactly one offset lands in range.
    always_comb
    begin
        r_next = '0;
        cand   = '0;
        for (int i = 0; i < 6; i++)
        begin
            cand = $signed({{2{angle[18]}}, angle}) + TURN_OFS[i];
            if (cand >= 21'sd0 && cand < $signed({4'd0, FULL_TURN}))
            begin
                r_next = cand[16:0];
            end
        end
    end

    // Quadrant and octant folding into [0, 45] degrees.
    always_comb
    begin
        if (r_reg >= THREE_QUART)
        begin
            quad_next = 2'd3;
            t_fold    = 15'(r_reg - THREE_QUART);
        end
        else if (r_reg >= HALF_TURN)
        begin
            quad_next = 2'd2;
            t_fold    = 15'(r_reg - HALF_TURN);
        end
        else if (r_reg >= QUARTER_TURN)
        begin
            quad_next = 2'd1;
            t_fold    = 15'(r_reg - QUARTER_TURN);
        end
        else
        begin
            quad_next = 2'd0;
            t_fold    = 15'(r_reg);
        end
        swap_next = t_fold > EIGHTH_T15;
        u_next    = swap_next ? 14'(QUARTER_T15 - t_fold) : 14'(t_fold);
    end

    assign xprod = 55'(nn_reg) * 55'(X_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            u_reg     <= u_next;
            quad_d[0] <= quad_next;
            swap_d[0] <= swap_next;
            for (int i = 1; i < FOLD_DLY; i++)
            begin
                quad_d[i] <= quad_d[i-1];
                swap_d[i] <= swap_d[i-1];
            end
            au_reg  <= 30'(31'(u_reg) * 31'(PI_A));
            nn_reg  <= 28'(28'(u_reg) * 28'(PI_B) + ROUND_OFS);
            x_reg   <= au_reg + 30'(xprod >> X_SHIFT);
            xx_reg  <= 60'(x_reg) * 60'(x_reg);
            x4_reg  <= x_reg;
            x2_reg  <= 31'((xx_reg + 60'(HALF_Q30)) >> 30);
            x5_reg  <= x4_reg;
            x_d[0]  <= x5_reg;
            for (int i = 1; i < X_DLY; i++)
            begin
                x_d[i] <= x_d[i-1];
            end
            x2_d[0] <= x2_reg;
            for (int i = 1; i < X2_DLY; i++)
            begin
                x2_d[i] <= x2_d[i-1];
            end
            sp_reg  <= 61'(x_d[X_DLY-1]) * 61'(sin_h[SIN_STEPS]);
            sq_reg  <= 31'((sp_reg + 61'(HALF_Q30)) >> 30);
            sq2_reg <= sq_reg;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_h[0] = ONE_Q30;
    assign cos_h[0] = ONE_Q30;

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        pis_horner u_step (
            .clk (clk),
            .en  (en),
            .x2  ((i == 0) ? x2_reg : x2_d[HORNER_LAT*i-1]),
            .t   (sin_h[i]),
            .k   (SIN_K[i]),
            .m   (SIN_M[i]),
            .h   (sin_h[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        pis_horner u_step (
            .clk (clk),
            .en  (en),
            .x2  ((i == 0) ? x2_reg : x2_d[HORNER_LAT*i-1]),
            .t   (cos_h[i]),
            .k   (COS_K[i]),
            .m   (COS_M[i]),
            .h   (cos_h[i+1])
        );
    end

    always_comb
    begin
        s0 = 25'((sq2_reg + 31'd32) >> 6);
        c0 = 25'((cos_h[COS_STEPS] + 31'd32) >> 6);
        if (swap_d[FOLD_DLY-1])
        begin
            s_fin = $signed({1'b0, c0});
            c_fin = $signed({1'b0, s0});
        end
        else
        begin
            s_fin = $signed({1'b0, s0});
            c_fin = $signed({1'b0, c0});
        end
        case (quad_d[FOLD_DLY-1])
            2'd0:
            begin
                sin_next = s_fin;
                cos_next = c_fin;
            end
            2'd1:
            begin
                sin_next = c_fin;
                cos_next = -s_fin;
            end
            2'd2:
            begin
                sin_next = -s_fin;
                cos_next = -c_fin;
            end
            default:
            begin
                sin_next = -c_fin;
                cos_next = s_fin;
            end
        endcase
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

[rtl/core/pis_dist.sv]
// Offsets, squared distance and the reach test, delayed to meet the trig results.
// Output is stage TRIG_LAST of the pipeline; depends on pis_pkg.
module pis_dist
    import pis_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] apex_x,
    input  logic signed [31:0] apex_y,
    input  logic signed [31:0] apex_z,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    input  logic [30:0]        tolerance_radius,
    input  logic [30:0]        sector_reach,
    output geom_t              geom
);

    localparam int DXZ_DLY  = TRIG_LAST;
    localparam int D2_DLY   = TRIG_LAST - 3;
    localparam int FLAG_DLY = TRIG_LAST - 4;

    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [31:0] span_reg, span1_reg;
    logic [31:0] ax_reg, ay_reg, az_reg;
    logic [63:0] sx_reg, sy_reg, sz_reg, span2_reg, span3_reg;
    logic [65:0] d2_reg;
    logic        apex_reg, far_reg;
    logic signed [32:0] dx_d [DXZ_DLY];
    logic signed [32:0] dz_d [DXZ_DLY];
    logic [65:0] d2_d [D2_DLY];
    logic        apex_d [FLAG_DLY];
    logic        far_d [FLAG_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= $signed({query_x[31], query_x}) - $signed({apex_x[31], apex_x});
            dy_reg    <= $signed({query_y[31], query_y}) - $signed({apex_y[31], apex_y});
            dz_reg    <= $signed({query_z[31], query_z}) - $signed({apex_z[31], apex_z});
            span_reg  <= 32'(sector_reach) + 32'(tolerance_radius);
            ax_reg    <= 32'(dx_reg[32] ? -dx_reg : dx_reg);
            ay_reg    <= 32'(dy_reg[32] ? -dy_reg : dy_reg);
            az_reg    <= 32'(dz_reg[32] ? -dz_reg : dz_reg);
            span1_reg <= span_reg;
            sx_reg    <= 64'(ax_reg) * 64'(ax_reg);
            sy_reg    <= 64'(ay_reg) * 64'(ay_reg);
            sz_reg    <= 64'(az_reg) * 64'(az_reg);
            span2_reg <= 64'(span1_reg) * 64'(span1_reg);
            d2_reg    <= 66'(sx_reg) + 66'(sy_reg) + 66'(sz_reg);
            span3_reg <= span2_reg;
            apex_reg  <= d2_reg == 66'd0;
            far_reg   <= 66'(span3_reg) < d2_reg;
            dx_d[0]   <= dx_reg;
            dz_d[0]   <= dz_reg;
            for (int i = 1; i < DXZ_DLY; i++)
            begin
                dx_d[i] <= dx_d[i-1];
                dz_d[i] <= dz_d[i-1];
            end
            d2_d[0] <= d2_reg;
            for (int i = 1; i < D2_DLY; i++)
            begin
                d2_d[i] <= d2_d[i-1];
            end
            apex_d[0] <= apex_reg;
            far_d[0]  <= far_reg;
            for (int i = 1; i < FLAG_DLY; i++)
            begin
                apex_d[i] <= apex_d[i-1];
                far_d[i]  <= far_d[i-1];
            end
        end
    end

    always_comb
    begin
        geom.dx   = dx_d[DXZ_DLY-1];
        geom.dz   = dz_d[DXZ_DLY-1];
        geom.d2   = d2_d[D2_DLY-1];
        geom.apex = apex_d[FLAG_DLY-1];
        geom.far  = far_d[FLAG_DLY-1];
    end

endmodule

[rtl/core/pis_dot.sv]
// Heading dot product against cos(half opening), compared squared without a root.
// Five stages ending in the decision register; depends on pis_pkg.
module pis_dot
    import pis_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  geom_t geom,
    input  trig_t head_sin,
    input  trig_t head_cos,
    input  trig_t half_cos,
    output logic  hit
);

    logic signed [59:0] n_reg, n_next;
    logic signed [51:0] csq;
    logic [48:0] ac2_reg, ac2b_reg;
    logic [65:0] d2a_reg, d2b_reg;
    logic [3:0]  apex_p, far_p, cpos_p, cneg_p;
    logic [2:0]  nneg_p;
    logic [58:0] an_reg;
    logic [63:0] l00_reg, rp00_reg;
    logic [58:0] l01_reg;
    logic [53:0] l11_reg;
    logic [48:0] rp01_reg;
    logic [65:0] rp10_reg;
    logic [50:0] rp11_reg;
    logic [PROD_W-1:0] lhs_reg, rhs_reg;
    logic        hit_reg, hit_next;

    always_comb
    begin
        n_next = $signed(60'(geom.dx)) * $signed(60'(head_cos))
               + $signed(60'(geom.dz)) * $signed(60'(head_sin));
        csq    = $signed(52'(half_cos)) * $signed(52'(half_cos));
    end

    // A point at the apex always hits; past reach it always misses.
    always_comb
    begin
        if (apex_p[3])
        begin
            hit_next = 1'b1;
        end
        else if (far_p[3])
        begin
            hit_next = 1'b0;
        end
        else if (!nneg_p[2])
        begin
            hit_next = !cpos_p[3] || (lhs_reg >= rhs_reg);
        end
        else
        begin
            hit_next = cneg_p[3] && (lhs_reg <= rhs_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            ac2_reg   <= 49'(csq);
            d2a_reg   <= geom.d2;
            apex_p    <= {apex_p[2:0], geom.apex};
            far_p     <= {far_p[2:0], geom.far};
            cpos_p    <= {cpos_p[2:0], !half_cos[25] && (half_cos != '0)};
            cneg_p    <= {cneg_p[2:0], half_cos[25]};
            an_reg    <= 59'(n_reg[59] ? -n_reg : n_reg);
            nneg_p    <= {nneg_p[1:0], n_reg[59]};
            ac2b_reg  <= ac2_reg;
            d2b_reg   <= d2a_reg;
            l00_reg   <= 64'(an_reg[31:0]) * 64'(an_reg[31:0]);
            l01_reg   <= 59'(an_reg[31:0]) * 59'(an_reg[58:32]);
            l11_reg   <= 54'(an_reg[58:32]) * 54'(an_reg[58:32]);
            rp00_reg  <= 64'(d2b_reg[31:0]) * 64'(ac2b_reg[31:0]);
            rp01_reg  <= 49'(d2b_reg[31:0]) * 49'(ac2b_reg[48:32]);
            rp10_reg  <= 66'(d2b_reg[65:32]) * 66'(ac2b_reg[31:0]);
            rp11_reg  <= 51'(d2b_reg[65:32]) * 51'(ac2b_reg[48:32]);
            lhs_reg   <= (PROD_W'(l11_reg) << 64) + (PROD_W'(l01_reg) << 33)
                       + PROD_W'(l00_reg);
            rhs_reg   <= (PROD_W'(rp11_reg) << 64)
                       + ((PROD_W'(rp01_reg) + PROD_W'(rp10_reg)) << 32)
                       + PROD_W'(rp00_reg);
            hit_reg   <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

[rtl/core/point_in_sector_test.sv]
// Point-in-sector test, top level.
// Input channel: in_valid / in_stall carry one query word (apex, heading, point,
// tolerance radius). Output channel: out_valid / out_stall carry inside_res.
// A word moves at a clock edge where valid is high and stall is low.
// The block is one pipeline of 27 register stages and takes a new word every
// cycle while the output is not held; the result of a word leaves from the last
// stage. The depth comes from the two sine/cosine units, whose Horner series
// steps each take three stages, followed by the squared dot test that splits
// its wide products over several stages.
// When out_valid is high and the receiver stalls, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and loads the opening angle (90 degrees) and reach
// (10.0). Registers are written through cfg_wr_en / cfg_index / cfg_data only
// while no query is in flight; the user must ensure this, the block does not enforce it.
// Indexes beyond the list are ignored. Depends on pis_pkg, pis_trig, pis_dist, pis_dot.
module point_in_sector_test
    import pis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] apex_x,
    input  logic signed [31:0] apex_y,
    input  logic signed [31:0] apex_z,
    input  logic signed [17:0] heading_angle,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    input  logic [30:0]        tolerance_radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               inside_res
);

    logic [15:0] opening_reg;
    logic [30:0] reach_reg;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic  en;
    trig_t head_sin, head_cos, half_cos;
    geom_t geom;

    assign en       = !(v_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opening_reg <= 16'd11520;
            reach_reg   <= 31'd655360;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OPENING: opening_reg <= cfg_data[15:0];
                REG_REACH:   reach_reg   <= cfg_data;
                default:     opening_reg <= opening_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    pis_trig u_head_trig (
        .clk   (clk),
        .en    (en),
        .angle ({heading_angle, 1'b0}),
        .sin_o (head_sin),
        .cos_o (head_cos)
    );

    // The opening register read in 1/256 degree is already the half angle.
    pis_trig u_half_trig (
        .clk   (clk),
        .en    (en),
        .angle ($signed({3'd0, opening_reg})),
        .sin_o (),
        .cos_o (half_cos)
    );

    pis_dist u_dist (
        .clk              (clk),
        .en               (en),
        .apex_x           (apex_x),
        .apex_y           (apex_y),
        .apex_z           (apex_z),
        .query_x          (query_x),
        .query_y          (query_y),
        .query_z          (query_z),
        .tolerance_radius (tolerance_radius),
        .sector_reach     (reach_reg),
        .geom             (geom)
    );

    pis_dot u_dot (
        .clk      (clk),
        .en       (en),
        .geom     (geom),
        .head_sin (head_sin),
        .head_cos (head_cos),
        .half_cos (half_cos),
        .hit      (inside_res)
    );

    assign out_valid = v_reg[PIPE_DEPTH-1];

    a_hold_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("valid bits moved while the pipeline was held");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted word did not enter the pipeline");

    a_drain_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (out_valid == $past(v_reg[PIPE_DEPTH-2])))
        else $error("pipeline did not advance after the output was taken");

endmodule
